@@ hw/rtl/dmg_pkg.sv @@
// Package for the damage rectangle table: rectangle type, result status codes
// and the saturating edge and containment helpers.
// Depends on nothing; imported by every module of the block.
package dmg_pkg;

    localparam int unsigned COORD_W = 14;
    localparam logic [COORD_W-1:0] COORD_MAX = 14'd16383;

    typedef struct packed {
        logic [COORD_W-1:0] h;
        logic [COORD_W-1:0] w;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] x;
    } rect_t;

    typedef logic [2:0] status_t;

    localparam status_t ST_ADDED     = 3'd0;
    localparam status_t ST_COVERED   = 3'd1;
    localparam status_t ST_COLLAPSED = 3'd2;
    localparam status_t ST_DRAINED   = 3'd3;
    localparam status_t ST_EMPTY     = 3'd4;

    // Far edge of a span, clipped to the coordinate range.
    function automatic logic [COORD_W-1:0] sat_end(input logic [COORD_W-1:0] a,
                                                   input logic [COORD_W-1:0] b);
        logic [COORD_W:0] s;
        begin
            s = {1'b0, a} + {1'b0, b};
            if (s > {1'b0, COORD_MAX})
                sat_end = COORD_MAX;
            else
                sat_end = s[COORD_W-1:0];
        end
    endfunction

    function automatic logic contains(input rect_t outer, input rect_t inner);
        begin
            contains = (inner.x >= outer.x) && (inner.y >= outer.y) &&
                       (sat_end(inner.x, inner.w) <= sat_end(outer.x, outer.w)) &&
                       (sat_end(inner.y, inner.h) <= sat_end(outer.y, outer.h));
        end
    endfunction

endpackage

@@ hw/rtl/dmg_rect_mem.sv @@
// Rectangle store: one write port and one registered read port.
// Depends on dmg_pkg for the rectangle type.
module dmg_rect_mem
    import dmg_pkg::*;
#(
    parameter int unsigned DEPTH = 16,
    parameter int unsigned AW    = $clog2(DEPTH)
)
(
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  rect_t         wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output rect_t         rd_data
);

    rect_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ hw/rtl/damage_rect_table_top.sv @@
// Damage rectangle table. An add checks the held entries one per cycle after a registered
// memory read, then registers its result in a finish state; the next transaction can be
// taken in the cycle that result is shown.
// A drain alternates a memory read state and an output state for each entry; an empty
// drain answers from the finish state. Output stalls hold the finish and output states.
// Reset clears the entry count and the head pointer; table contents stay undefined.
module damage_rect_table_top
    import dmg_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = 16
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic                             action,
    input  logic [13:0]                      rect_x,
    input  logic [13:0]                      rect_y,
    input  logic [13:0]                      rect_w,
    input  logic [13:0]                      rect_h,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [2:0]                       status,
    output logic [13:0]                      out_x,
    output logic [13:0]                      out_y,
    output logic [13:0]                      out_w,
    output logic [13:0]                      out_h,
    output logic [$clog2(TABLE_DEPTH+1)-1:0] entry_total,
    output logic                             last
);

    localparam int unsigned AW = $clog2(TABLE_DEPTH);
    localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [2:0] {S_IDLE, S_WALK, S_FINISH, S_DRAIN_RD, S_DRAIN_OUT} state_t;

    // Logical entry index to memory address; the table is a ring with the
    // newest entry at the base pointer.
    function automatic logic [AW-1:0] phys(input logic [AW-1:0] b, input logic [CW-1:0] l);
        logic [AW:0] s;
        begin
            s = (AW+1)'(b) + (AW+1)'(l);
            if (s >= (AW+1)'(TABLE_DEPTH))
                s = s - (AW+1)'(TABLE_DEPTH);
            phys = s[AW-1:0];
        end
    endfunction

    state_t        state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [AW-1:0] base_reg, base_next;
    logic [CW-1:0] rd_idx_reg, rd_idx_next;
    logic [CW-1:0] kept_reg, kept_next;
    logic          ev_valid_reg, ev_valid_next;
    logic          covered_reg, covered_next;
    logic          drain_reg, drain_next;
    rect_t         nr_reg, nr_next;
    rect_t         head_reg, head_next;
    logic [13:0]   bx0_reg, bx0_next, by0_reg, by0_next;
    logic [13:0]   bx1_reg, bx1_next, by1_reg, by1_next;

    logic          out_valid_reg, out_valid_next;
    status_t       status_reg, status_next;
    rect_t         out_rect_reg, out_rect_next;
    logic [CW-1:0] total_reg, total_next;
    logic          last_reg, last_next;

    logic          mem_wr_en, mem_rd_en;
    logic [AW-1:0] mem_wr_addr, mem_rd_addr;
    rect_t         mem_wr_data, mem_rd_data;

    logic          in_fire, out_free;
    rect_t         in_rect, ev_rect;
    logic [13:0]   ex1, ey1;

    dmg_rect_mem #(
        .DEPTH (TABLE_DEPTH)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    assign in_stall = (state_reg != S_IDLE);
    assign in_fire  = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign in_rect  = '{h: rect_h, w: rect_w, y: rect_y, x: rect_x};
    assign ev_rect  = mem_rd_data;
    assign ex1      = sat_end(ev_rect.x, ev_rect.w);
    assign ey1      = sat_end(ev_rect.y, ev_rect.h);

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        base_next      = base_reg;
        rd_idx_next    = rd_idx_reg;
        kept_next      = kept_reg;
        ev_valid_next  = 1'b0;
        covered_next   = covered_reg;
        drain_next     = drain_reg;
        nr_next        = nr_reg;
        head_next      = head_reg;
        bx0_next       = bx0_reg;
        by0_next       = by0_reg;
        bx1_next       = bx1_reg;
        by1_next       = by1_reg;
        out_valid_next = out_valid_reg && out_stall;
        status_next    = status_reg;
        out_rect_next  = out_rect_reg;
        total_next     = total_reg;
        last_next      = last_reg;
        mem_wr_en      = 1'b0;
        mem_wr_addr    = phys(base_reg, kept_reg);
        mem_wr_data    = ev_rect;
        mem_rd_en      = 1'b0;
        mem_rd_addr    = phys(base_reg, rd_idx_reg);

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    nr_next      = in_rect;
                    drain_next   = action;
                    covered_next = 1'b0;
                    rd_idx_next  = '0;
                    kept_next    = '0;
                    bx0_next     = rect_x;
                    by0_next     = rect_y;
                    bx1_next     = sat_end(rect_x, rect_w);
                    by1_next     = sat_end(rect_y, rect_h);
                    if (!action)
                        state_next = S_WALK;
                    else if (count_reg == '0)
                        state_next = S_FINISH;
                    else
                        state_next = S_DRAIN_RD;
                end
            end

            S_WALK:
            begin
                // Read of the next entry overlaps evaluation of the current one.
                // Writes go to the kept index, which never passes the read index.
                if (rd_idx_reg < count_reg)
                begin
                    mem_rd_en     = 1'b1;
                    rd_idx_next   = rd_idx_reg + 1'b1;
                    ev_valid_next = 1'b1;
                end
                if (ev_valid_reg)
                begin
                    if (covered_reg || contains(ev_rect, nr_reg) || !contains(nr_reg, ev_rect))
                    begin
                        mem_wr_en = 1'b1;
                        kept_next = kept_reg + 1'b1;
                        if (kept_reg == '0)
                            head_next = ev_rect;
                        if (!covered_reg && contains(ev_rect, nr_reg))
                        begin
                            covered_next = 1'b1;
                        end
                        else if (!covered_reg)
                        begin
                            if (ev_rect.x < bx0_reg) bx0_next = ev_rect.x;
                            if (ev_rect.y < by0_reg) by0_next = ev_rect.y;
                            if (ex1 > bx1_reg)       bx1_next = ex1;
                            if (ey1 > by1_reg)       by1_next = ey1;
                        end
                    end
                end
                else if (rd_idx_reg == count_reg)
                begin
                    state_next = S_FINISH;
                end
            end

            S_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    last_next      = 1'b1;
                    state_next     = S_IDLE;
                    priority if (drain_reg)
                    begin
                        status_next   = ST_EMPTY;
                        out_rect_next = '0;
                        total_next    = '0;
                        count_next    = '0;
                    end
                    else if (covered_reg)
                    begin
                        status_next   = ST_COVERED;
                        out_rect_next = head_reg;
                        total_next    = kept_reg;
                        count_next    = kept_reg;
                    end
                    else if (kept_reg == CW'(TABLE_DEPTH))
                    begin
                        status_next   = ST_COLLAPSED;
                        out_rect_next = '{h: by1_reg - by0_reg, w: bx1_reg - bx0_reg,
                                          y: by0_reg, x: bx0_reg};
                        total_next    = CW'(1);
                        count_next    = CW'(1);
                        mem_wr_en     = 1'b1;
                        mem_wr_addr   = base_reg;
                        mem_wr_data   = out_rect_next;
                    end
                    else
                    begin
                        status_next   = ST_ADDED;
                        out_rect_next = nr_reg;
                        total_next    = kept_reg + 1'b1;
                        count_next    = kept_reg + 1'b1;
                        base_next     = (base_reg == '0) ? AW'(TABLE_DEPTH - 1)
                                                         : base_reg - 1'b1;
                        mem_wr_en     = 1'b1;
                        mem_wr_addr   = base_next;
                        mem_wr_data   = nr_reg;
                    end
                end
            end

            S_DRAIN_RD:
            begin
                mem_rd_en  = 1'b1;
                state_next = S_DRAIN_OUT;
            end

            S_DRAIN_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    status_next    = ST_DRAINED;
                    out_rect_next  = ev_rect;
                    total_next     = '0;
                    last_next      = (rd_idx_reg + 1'b1 == count_reg);
                    rd_idx_next    = rd_idx_reg + 1'b1;
                    if (last_next)
                    begin
                        count_next = '0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_DRAIN_RD;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            base_reg      <= '0;
            rd_idx_reg    <= '0;
            kept_reg      <= '0;
            ev_valid_reg  <= 1'b0;
            covered_reg   <= 1'b0;
            drain_reg     <= 1'b0;
            nr_reg        <= '0;
            head_reg      <= '0;
            bx0_reg       <= '0;
            by0_reg       <= '0;
            bx1_reg       <= '0;
            by1_reg       <= '0;
            out_valid_reg <= 1'b0;
            status_reg    <= ST_ADDED;
            out_rect_reg  <= '0;
            total_reg     <= '0;
            last_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            base_reg      <= base_next;
            rd_idx_reg    <= rd_idx_next;
            kept_reg      <= kept_next;
            ev_valid_reg  <= ev_valid_next;
            covered_reg   <= covered_next;
            drain_reg     <= drain_next;
            nr_reg        <= nr_next;
            head_reg      <= head_next;
            bx0_reg       <= bx0_next;
            by0_reg       <= by0_next;
            bx1_reg       <= bx1_next;
            by1_reg       <= by1_next;
            out_valid_reg <= out_valid_next;
            status_reg    <= status_next;
            out_rect_reg  <= out_rect_next;
            total_reg     <= total_next;
            last_reg      <= last_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign out_x       = out_rect_reg.x;
    assign out_y       = out_rect_reg.y;
    assign out_w       = out_rect_reg.w;
    assign out_h       = out_rect_reg.h;
    assign entry_total = total_reg;
    assign last        = last_reg;

endmodule

@@ hw/rtl/dmg_checker.sv @@
// Port-level checks for the damage rectangle table, bound to the top level.
// Depends on dmg_pkg for the status codes.
module dmg_checker
    import dmg_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = 16
)
(
    input logic                             clk,
    input logic                             rst_n,
    input logic                             in_valid,
    input logic                             in_stall,
    input logic                             out_valid,
    input logic                             out_stall,
    input logic [2:0]                       status,
    input logic [13:0]                      out_x,
    input logic [13:0]                      out_y,
    input logic [13:0]                      out_w,
    input logic [13:0]                      out_h,
    input logic [$clog2(TABLE_DEPTH+1)-1:0] entry_total,
    input logic                             last
);

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // An accepted transaction keeps the block busy for at least the next cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken again right after an accept");

    // Only drained entries can be anything but the final result.
    a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_DRAINED |-> last)
        else $error("add or empty drain result without last");

    // An empty drain reports zero coordinates and an empty table.
    a_empty_drain: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_EMPTY |->
            entry_total == '0 && out_x == '0 && out_y == '0 && out_w == '0 && out_h == '0)
        else $error("empty drain result carries data");

    // A collapse leaves exactly one entry; a drain leaves none.
    a_totals: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_COLLAPSED || status == ST_DRAINED) |->
            entry_total == ((status == ST_COLLAPSED) ? 1 : 0))
        else $error("wrong entry total after collapse or drain");

endmodule

bind damage_rect_table_top dmg_checker #(.TABLE_DEPTH(TABLE_DEPTH)) u_dmg_checker (.*);

@@ test/damage_rect_table_top_test.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for damage_rect_table_top. It checks adds, pruning, overflow
// collapse and drains against a predictor of the table that runs inside the testbench.
// Depends on dmg_pkg for the rectangle type and status codes, and on the block's RTL.
module damage_rect_table_top_test;
    import dmg_pkg::*;

    localparam int unsigned DEPTH = 16;
    localparam logic ACT_ADD = 1'b0;
    localparam logic ACT_DRAIN = 1'b1;
    localparam int unsigned SETTLE_CYCLES = 48;

    typedef struct packed {
        status_t    status;
        rect_t      area;
        logic [4:0] total;
        logic       last;
    } damage_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic action = 1'b0;
    logic [13:0] rect_x = '0;
    logic [13:0] rect_y = '0;
    logic [13:0] rect_w = '0;
    logic [13:0] rect_h = '0;
    logic out_stall = 1'b0;
    logic in_stall;
    logic out_valid;
    logic [2:0] status;
    logic [13:0] out_x;
    logic [13:0] out_y;
    logic [13:0] out_w;
    logic [13:0] out_h;
    logic [4:0] entry_total;
    logic last;

    // Copy of the table as the block should hold it, newest entry at index 0.
    rect_t held_rects[DEPTH];
    int unsigned held_count = 0;
    damage_result_t expected_results[$];
    int unsigned error_count = 0;
    bit idle_on = 1'b1;
    int unsigned out_stall_left = 0;

    damage_rect_table_top u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .action      (action),
        .rect_x      (rect_x),
        .rect_y      (rect_y),
        .rect_w      (rect_w),
        .rect_h      (rect_h),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .out_x       (out_x),
        .out_y       (out_y),
        .out_w       (out_w),
        .out_h       (out_h),
        .entry_total (entry_total),
        .last        (last)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic logic [13:0] clipped_end(input logic [13:0] a, input logic [13:0] b);
        int unsigned s;
        begin
            s = a + b;
            return (s > 16383) ? 14'd16383 : s[13:0];
        end
    endfunction

    function automatic bit covers(input rect_t outer, input rect_t inner);
        begin
            return inner.x >= outer.x && inner.y >= outer.y &&
                   clipped_end(inner.x, inner.w) <= clipped_end(outer.x, outer.w) &&
                   clipped_end(inner.y, inner.h) <= clipped_end(outer.y, outer.h);
        end
    endfunction

    task automatic push_result(input status_t st, input rect_t r, input int unsigned total,
                               input bit is_last);
        damage_result_t res;
        begin
            res.status = st;
            res.area = r;
            res.total = total[4:0];
            res.last = is_last;
            expected_results.push_back(res);
        end
    endtask

    // Updates the table copy for one accepted transaction and queues its results.
    task automatic apply_damage_op(input logic act, input rect_t nr);
        rect_t kept_rects[DEPTH];
        rect_t box;
        int unsigned kept;
        int unsigned i;
        int unsigned j;
        logic [13:0] x1;
        logic [13:0] y1;
        begin
            kept = 0;
            if (act == ACT_DRAIN)
            begin
                if (held_count == 0)
                    push_result(ST_EMPTY, '0, 0, 1'b1);
                for (i = 0; i < held_count; i++)
                    push_result(ST_DRAINED, held_rects[i], 0, i + 1 == held_count);
                held_count = 0;
                return;
            end
            for (i = 0; i < held_count; i++)
            begin
                // Entries pruned before the covering one stay pruned.
                if (covers(held_rects[i], nr))
                begin
                    for (j = i; j < held_count; j++)
                    begin
                        kept_rects[kept] = held_rects[j];
                        kept++;
                    end
                    for (j = 0; j < kept; j++)
                        held_rects[j] = kept_rects[j];
                    held_count = kept;
                    push_result(ST_COVERED, held_rects[0], kept, 1'b1);
                    return;
                end
                if (!covers(nr, held_rects[i]))
                begin
                    kept_rects[kept] = held_rects[i];
                    kept++;
                end
            end
            if (kept >= DEPTH)
            begin
                box.x = nr.x;
                box.y = nr.y;
                x1 = clipped_end(nr.x, nr.w);
                y1 = clipped_end(nr.y, nr.h);
                for (i = 0; i < kept; i++)
                begin
                    if (kept_rects[i].x < box.x)
                        box.x = kept_rects[i].x;
                    if (kept_rects[i].y < box.y)
                        box.y = kept_rects[i].y;
                    if (clipped_end(kept_rects[i].x, kept_rects[i].w) > x1)
                        x1 = clipped_end(kept_rects[i].x, kept_rects[i].w);
                    if (clipped_end(kept_rects[i].y, kept_rects[i].h) > y1)
                        y1 = clipped_end(kept_rects[i].y, kept_rects[i].h);
                end
                box.w = x1 - box.x;
                box.h = y1 - box.y;
                held_rects[0] = box;
                held_count = 1;
                push_result(ST_COLLAPSED, box, 1, 1'b1);
                return;
            end
            held_rects[0] = nr;
            for (i = 0; i < kept; i++)
                held_rects[i + 1] = kept_rects[i];
            held_count = kept + 1;
            push_result(ST_ADDED, nr, held_count, 1'b1);
        end
    endtask

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        begin
            $display("mismatch on %s at %0t: got %0d, expected %0d", what, $realtime, got,
                     want);
            error_count++;
        end
    endtask

    task automatic check_result();
        damage_result_t want;
        begin
            if (expected_results.size() == 0)
            begin
                report_mismatch("status of unexpected result", status, 0);
                return;
            end
            want = expected_results.pop_front();
            if (status !== want.status)
                report_mismatch("status", status, want.status);
            if (out_x !== want.area.x)
                report_mismatch("out_x", out_x, want.area.x);
            if (out_y !== want.area.y)
                report_mismatch("out_y", out_y, want.area.y);
            if (out_w !== want.area.w)
                report_mismatch("out_w", out_w, want.area.w);
            if (out_h !== want.area.h)
                report_mismatch("out_h", out_h, want.area.h);
            if (entry_total !== want.total)
                report_mismatch("entry_total", entry_total, want.total);
            if (last !== want.last)
                report_mismatch("last", last, want.last);
        end
    endtask

    // Result side: check each accepted result, then pick the next stall.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                check_result();
            if (out_stall_left != 0)
            begin
                out_stall_left--;
                out_stall <= 1'b1;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                out_stall_left = $urandom_range(1, 16) - 1;
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // Valid stays high after a transaction so back-to-back sends need no extra step;
    // a random idle gap in send_op or wait_all_results lowers it.
    task automatic send_op(input logic act, input logic [13:0] x, input logic [13:0] y,
                           input logic [13:0] w, input logic [13:0] h);
        rect_t r;
        begin
            if (idle_on && $urandom_range(0, 3) == 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
            in_valid <= 1'b1;
            action <= act;
            rect_x <= x;
            rect_y <= y;
            rect_w <= w;
            rect_h <= h;
            @(posedge clk);
            while (in_stall)
                @(posedge clk);
            r.x = x;
            r.y = y;
            r.w = w;
            r.h = h;
            apply_damage_op(act, r);
        end
    endtask

    task automatic send_drain();
        begin
            send_op(ACT_DRAIN, 14'($urandom), 14'($urandom), 14'($urandom), 14'($urandom));
        end
    endtask

    task automatic wait_all_results();
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while (expected_results.size() != 0)
                @(posedge clk);
            repeat (SETTLE_CYCLES) @(posedge clk);
        end
    endtask

    task automatic test_empty_drain();
        begin
            send_drain();
        end
    endtask

    task automatic test_field_extremes();
        begin
            send_op(ACT_ADD, 14'd0, 14'd0, 14'd0, 14'd0);
            send_op(ACT_ADD, 14'h3FFF, 14'h3FFF, 14'h3FFF, 14'h3FFF);
            // Both far edges saturate here.
            send_op(ACT_ADD, 14'd5000, 14'd6000, 14'h3FFF, 14'h3FFF);
            send_op(ACT_ADD, 14'd0, 14'd0, 14'd0, 14'd0);
        end
    endtask

    task automatic test_prune_then_cover();
        begin
            send_op(ACT_ADD, 14'd0, 14'd0, 14'h3FFF, 14'h3FFF);
            send_op(ACT_ADD, 14'd100, 14'd100, 14'd1000, 14'd1000);
            send_op(ACT_ADD, 14'd200, 14'd200, 14'd10, 14'd10);
            // Falls inside the full-range entry, so it is reported as covered.
            send_op(ACT_ADD, 14'd150, 14'd150, 14'd100, 14'd100);
            send_drain();
        end
    endtask

    task automatic test_overflow_collapse();
        int unsigned i;
        begin
            for (i = 0; i < DEPTH; i++)
                send_op(ACT_ADD, 14'(i * 1000), 14'(i * 500), 14'd50, 14'd60);
            send_op(ACT_ADD, 14'd16000, 14'd16000, 14'd1000, 14'd1000);
            send_drain();
        end
    endtask

    // Bursts of adds closed by a drain; one burst style lines up disjoint rectangles
    // so that the table fills and collapses.
    task automatic test_random_traffic(input int unsigned item_goal);
        int unsigned sent;
        int unsigned burst;
        int unsigned style;
        int unsigned k;
        logic [13:0] x;
        logic [13:0] y;
        logic [13:0] w;
        logic [13:0] h;
        begin
            sent = 0;
            while (sent < item_goal)
            begin
                style = $urandom_range(0, 2);
                burst = (style == 2) ? $urandom_range(14, 24) : $urandom_range(1, 24);
                for (k = 0; k < burst; k++)
                begin
                    case (style == 2 ? 5 : $urandom_range(0, 9))
                        0:
                        begin
                            x = 14'($urandom); y = 14'($urandom);
                            w = 14'($urandom); h = 14'($urandom);
                        end
                        1, 2, 3, 4:
                        begin
                            x = 14'($urandom_range(0, 48)); y = 14'($urandom_range(0, 48));
                            w = 14'($urandom_range(0, 64)); h = 14'($urandom_range(0, 64));
                        end
                        5, 6:
                        begin
                            x = 14'($urandom_range(0, 15) * 1024 + $urandom_range(0, 500));
                            y = 14'($urandom_range(0, 15) * 1024 + $urandom_range(0, 500));
                            w = 14'($urandom_range(1, 400)); h = 14'($urandom_range(1, 400));
                        end
                        7:
                        begin
                            x = 14'($urandom_range(0, 4)); y = 14'($urandom_range(0, 4));
                            w = 14'($urandom_range(60, 2000));
                            h = 14'($urandom_range(60, 2000));
                        end
                        8:
                        begin
                            x = 14'($urandom_range(16000, 16383));
                            y = 14'($urandom_range(16000, 16383));
                            w = 14'($urandom); h = 14'($urandom);
                        end
                        default:
                        begin
                            x = 14'($urandom); y = 14'($urandom);
                            w = $urandom_range(0, 1) ? 14'd0 : 14'($urandom);
                            h = (w != 0) ? 14'd0 : 14'($urandom);
                        end
                    endcase
                    send_op(ACT_ADD, x, y, w, h);
                    sent++;
                end
                send_drain();
                sent++;
            end
        end
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_drain();
        test_field_extremes();
        test_prune_then_cover();
        test_overflow_collapse();
        wait_all_results();
        test_random_traffic(80);
        idle_on = 1'b0;
        test_random_traffic(25);
        wait_all_results();
        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
